FILE: hw/rtl/dce_pkg.sv
// ----------------------------------------------------------------------------
// dce_pkg
// Shared types and codes for the date component extractor pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dce_pkg;

	// number of register stages from request to response
	localparam int unsigned STAGES = 12;

	// component selector codes
	localparam logic [3:0] CMD_DAY      = 4'd0;
	localparam logic [3:0] CMD_MONTH    = 4'd1;
	localparam logic [3:0] CMD_YEAR     = 4'd2;
	localparam logic [3:0] CMD_WEEKDAY  = 4'd3;
	localparam logic [3:0] CMD_ORDINAL  = 4'd4;
	localparam logic [3:0] CMD_ISOWDAY  = 4'd5;
	localparam logic [3:0] CMD_WEEK     = 4'd6;
	localparam logic [3:0] CMD_WEEKYEAR = 4'd7;
	localparam logic [3:0] CMD_QUARTER  = 4'd8;
	localparam logic [3:0] CMD_DOQ      = 4'd9;

	// per-stage load enables and occupancy
	typedef struct packed {
		logic [STAGES-1:0] load;
		logic [STAGES-1:0] vld;
	} pipe_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dce_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// dce_pipe_ctrl
// Valid bits and load enables of the datapath; empty stages fill under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module dce_pipe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              rsp_ready,
	output dce_pkg::pipe_ctl_t ctl
);

	logic [dce_pkg::STAGES-1:0] vld_q;
	logic [dce_pkg::STAGES-1:0] load;
	logic                       in_acc;
	logic                       out_acc;

	always_comb begin
		load[dce_pkg::STAGES-1] = !vld_q[dce_pkg::STAGES-1] || rsp_ready;
		for (int i = dce_pkg::STAGES-2; i >= 0; i--) begin
			load[i] = !vld_q[i] || load[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (load[0]) begin
				vld_q[0] <= req_valid;
			end
			for (int i = 1; i < dce_pkg::STAGES; i++) begin
				if (load[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign ctl.load = load;
	assign ctl.vld  = vld_q;

	assign in_acc  = req_valid && load[0];
	assign out_acc = vld_q[dce_pkg::STAGES-1] && rsp_ready;

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> vld_q[0])
		else $error("accepted word missing from first stage");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !out_acc) |=> ($countones(vld_q) == $past($countones(vld_q)) + 1))
		else $error("occupancy did not grow on accept");

	a_cnt_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_acc && out_acc) |=> ($countones(vld_q) + 1 == $past($countones(vld_q))))
		else $error("occupancy did not shrink on delivery");

	a_cnt_eq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc == out_acc) |=> ($countones(vld_q) == $past($countones(vld_q))))
		else $error("word lost or duplicated in pipeline");

endmodule

`default_nettype wire

FILE: hw/rtl/date_component_extract_core.sv
// ----------------------------------------------------------------------------
// date_component_extract_core
// Epoch seconds to one UTC calendar component (civil date, weekday, ISO week).
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Payload
// request   in   req_valid/req_ready    command, epoch_seconds
// response  out  rsp_valid/rsp_ready    component_value, valid_res
//
// One word per cycle while rsp_ready is high or an empty stage remains.
// The deepest stage is the 32x32 reciprocal multiply that divides by 86400;
// later divisions by constants are reciprocal multiplies in later stages.
// Reset clears only the stage valid bits.
// A full stage holds while the one after it is blocked; empty stages keep
// filling, so req_ready stays high until all 12 stages are occupied and rsp_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module date_component_extract_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [3:0]         command,
	input  logic signed [38:0] epoch_seconds,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [13:0]        component_value,
	output logic               valid_res
);

	// 0001-01-01T00:00:00 is -EPOCH_OFS, span to 9999-12-31T23:59:59
	localparam logic signed [39:0] EPOCH_OFS = 40'sd62135596800;
	localparam logic signed [39:0] SPAN      = 40'sd315537897599;

	// reciprocals: floor for 675 (corrected), ceil (exact) elsewhere
	localparam logic [31:0] M_675   = 32'((64'd1 << 41) / 64'd675);
	localparam logic [22:0] M_ERA   = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
	localparam logic [18:0] M_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam logic [18:0] M_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
	localparam logic [18:0] M_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam logic [9:0]  M_100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
	localparam logic [11:0] M_153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
	localparam logic [14:0] M5_153  = 15'(64'(M_153) * 64'd5);
	localparam logic [13:0] M2_153  = 14'(64'(M_153) * 64'd2);
	localparam logic [9:0]  M_7     = 10'(((64'd1 << 12) + 64'd6) / 64'd7);

	function automatic logic [2:0] mod7(input logic [21:0] x);
		logic [23:0] xw;
		logic [5:0]  acc;
		logic [3:0]  fold;
		xw  = {2'b00, x};
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			acc = acc + 6'(xw[3*i +: 3]);
		end
		fold = 4'(acc[5:3]) + 4'(acc[2:0]);
		if (fold >= 4'd7) begin
			fold = fold - 4'd7;
		end
		return 3'(fold);
	endfunction

	// day offset of each March-based month
	function automatic logic [8:0] mp_start(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	dce_pkg::pipe_ctl_t ctl;

	dce_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.rsp_ready (rsp_ready),
		.ctl       (ctl)
	);

	assign req_ready = ctl.load[0];
	assign rsp_valid = ctl.vld[dce_pkg::STAGES-1];

	// ---------------- stage 1: clamp and rebase to 0001-01-01 ----------------
	logic signed [39:0] sec_ofs;
	logic [38:0]        sec_clamp;
	logic [31:0]        v_s1;
	logic [3:0]         cmd_s1;

	always_comb begin
		sec_ofs = {epoch_seconds[38], epoch_seconds} + EPOCH_OFS;
		if (sec_ofs[39]) begin
			sec_clamp = '0;
		end else if (sec_ofs > SPAN) begin
			sec_clamp = SPAN[38:0];
		end else begin
			sec_clamp = sec_ofs[38:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			v_s1   <= sec_clamp[38:7];
			cmd_s1 <= command;
		end
	end

	// ---------------- stage 2: estimate (sec >> 7) / 675 ----------------
	logic [63:0] p675;
	logic [21:0] qest_s2;
	logic [31:0] v_s2;
	logic [3:0]  cmd_s2;

	assign p675 = v_s1 * M_675;

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			qest_s2 <= p675[62:41];
			v_s2    <= v_s1;
			cmd_s2  <= cmd_s1;
		end
	end

	// ---------------- stage 3: correct quotient, shift to March-based z ------
	logic [31:0] rem675;
	logic [21:0] z_s3;
	logic [3:0]  cmd_s3;

	assign rem675 = v_s2 - 32'(qest_s2) * 32'd675;

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			z_s3   <= qest_s2 + 22'd306 + 22'(rem675 >= 32'd675);
			cmd_s3 <= cmd_s2;
		end
	end

	// ---------------- stage 4: era, weekday ----------------
	logic [44:0] pera;
	logic [4:0]  era_s4;
	logic [21:0] z_s4;
	logic [2:0]  wday_s4;
	logic [3:0]  cmd_s4;

	assign pera = z_s3 * M_ERA;

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			era_s4  <= pera[44:40];
			z_s4    <= z_s3;
			wday_s4 <= mod7(z_s3 + 22'd3);
			cmd_s4  <= cmd_s3;
		end
	end

	// ---------------- stage 5: day of era ----------------
	logic [17:0] doe_s5;
	logic [4:0]  era_s5;
	logic [2:0]  wday_s5;
	logic [3:0]  cmd_s5;

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			doe_s5  <= 18'(z_s4 - 22'(era_s4) * 22'd146097);
			era_s5  <= era_s4;
			wday_s5 <= wday_s4;
			cmd_s5  <= cmd_s4;
		end
	end

	// ---------------- stage 6: leap-corrected day count ----------------
	logic [36:0] p1460;
	logic [36:0] p36524;
	logic [17:0] t_s6;
	logic [17:0] doe_s6;
	logic [4:0]  era_s6;
	logic [2:0]  wday_s6;
	logic [3:0]  cmd_s6;

	assign p1460  = doe_s5 * M_1460;
	assign p36524 = doe_s5 * M_36524;

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			t_s6    <= doe_s5 - 18'(p1460[35:29]) + 18'(p36524[36:34])
				- 18'(doe_s5 == 18'd146096);
			doe_s6  <= doe_s5;
			era_s6  <= era_s5;
			wday_s6 <= wday_s5;
			cmd_s6  <= cmd_s5;
		end
	end

	// ---------------- stage 7: year of era ----------------
	logic [36:0] p365;
	logic [8:0]  yoe_s7;
	logic [17:0] doe_s7;
	logic [4:0]  era_s7;
	logic [2:0]  wday_s7;
	logic [3:0]  cmd_s7;

	assign p365 = t_s6 * M_365;

	always_ff @(posedge clk) begin
		if (ctl.load[6]) begin
			yoe_s7  <= p365[35:27];
			doe_s7  <= doe_s6;
			era_s7  <= era_s6;
			wday_s7 <= wday_s6;
			cmd_s7  <= cmd_s6;
		end
	end

	// ---------------- stage 8: day of March-based year ----------------
	logic [18:0] p100;
	logic [1:0]  yc;
	logic [17:0] dbase;
	logic [8:0]  doy_s8;
	logic [8:0]  yoe_s8;
	logic [1:0]  yc_s8;
	logic [4:0]  era_s8;
	logic [2:0]  wday_s8;
	logic [3:0]  cmd_s8;

	assign p100  = yoe_s7 * M_100;
	assign yc    = p100[17:16];
	assign dbase = 18'(yoe_s7) * 18'd365 + 18'(yoe_s7[8:2]) - 18'(yc);

	always_ff @(posedge clk) begin
		if (ctl.load[7]) begin
			doy_s8  <= 9'(doe_s7 - dbase);
			yoe_s8  <= yoe_s7;
			yc_s8   <= yc;
			era_s8  <= era_s7;
			wday_s8 <= wday_s7;
			cmd_s8  <= cmd_s7;
		end
	end

	// ---------------- stage 9: month index, leap flags, base year ----------
	logic [23:0] p153;
	logic [6:0]  r100;
	logic [3:0]  mp_s9;
	logic [8:0]  doy_s9;
	logic [13:0] ybase_s9;
	logic        leap_y_s9;
	logic        leap_yn_s9;
	logic        leap_yp_s9;
	logic [2:0]  wday_s9;
	logic [3:0]  cmd_s9;

	assign p153 = doy_s8 * M5_153 + 24'(M2_153);
	assign r100 = 7'(yoe_s8 - 9'(yc_s8) * 9'd100);

	always_ff @(posedge clk) begin
		if (ctl.load[8]) begin
			mp_s9      <= p153[22:19];
			doy_s9     <= doy_s8;
			ybase_s9   <= 14'(yoe_s8) + 14'(era_s8) * 14'd400;
			leap_y_s9  <= (yoe_s8[1:0] == 2'd0) && (r100 != 7'd0 || yoe_s8 == 9'd0);
			leap_yn_s9 <= (yoe_s8 == 9'd399) || (yoe_s8[1:0] == 2'd3 && r100 != 7'd99);
			leap_yp_s9 <= (yoe_s8[1:0] == 2'd1) && (r100 != 7'd1 || yoe_s8 == 9'd1);
			wday_s9    <= wday_s8;
			cmd_s9     <= cmd_s8;
		end
	end

	// ---------------- stage 10: civil date, ordinal day ----------------
	logic        janfeb;
	logic [4:0]  mday_s10;
	logic [3:0]  month_s10;
	logic [13:0] year_s10;
	logic [8:0]  ord_s10;
	logic        leap_s10;
	logic        leap_prev_s10;
	logic [2:0]  wday_s10;
	logic [3:0]  cmd_s10;

	assign janfeb = mp_s9 >= 4'd10;

	always_ff @(posedge clk) begin
		if (ctl.load[9]) begin
			mday_s10      <= 5'(doy_s9 - mp_start(mp_s9) + 9'd1);
			month_s10     <= janfeb ? 4'(mp_s9 - 4'd9) : 4'(mp_s9 + 4'd3);
			year_s10      <= ybase_s9 + 14'(janfeb);
			ord_s10       <= janfeb ? 9'(doy_s9 - 9'd305)
				: 9'(doy_s9 + 9'd60 + 9'(leap_y_s9));
			leap_s10      <= janfeb ? leap_yn_s9 : leap_y_s9;
			leap_prev_s10 <= janfeb ? leap_y_s9 : leap_yp_s9;
			wday_s10      <= wday_s9;
			cmd_s10       <= cmd_s9;
		end
	end

	// ---------------- stage 11: quarter, day of quarter, ISO weekday and week-year ----------------
	logic [2:0]  quarter;
	logic [8:0]  qoff;
	logic [2:0]  mon_idx;
	logic [9:0]  u;
	logic [9:0]  diy;
	logic [13:0] wyear;
	logic [8:0]  tm1;

	logic [4:0]  mday_s11;
	logic [3:0]  month_s11;
	logic [13:0] year_s11;
	logic [8:0]  ord_s11;
	logic [2:0]  wday_s11;
	logic [2:0]  isowd_s11;
	logic [2:0]  quarter_s11;
	logic [6:0]  doq_s11;
	logic [13:0] wyear_s11;
	logic [8:0]  tm1_s11;
	logic [3:0]  cmd_s11;

	always_comb begin
		priority if (month_s10 <= 4'd3) begin
			quarter = 3'd1;
			qoff    = 9'd0;
		end else if (month_s10 <= 4'd6) begin
			quarter = 3'd2;
			qoff    = 9'd90 + 9'(leap_s10);
		end else if (month_s10 <= 4'd9) begin
			quarter = 3'd3;
			qoff    = 9'd181 + 9'(leap_s10);
		end else begin
			quarter = 3'd4;
			qoff    = 9'd273 + 9'(leap_s10);
		end

		// Monday = 0; u is the Thursday's ordinal plus 3
		mon_idx = (wday_s10 == 3'd0) ? 3'd6 : 3'(wday_s10 - 3'd1);
		u       = 10'(ord_s10) + 10'd6 - 10'(mon_idx);
		diy     = 10'd365 + 10'(leap_s10);

		priority if (u < 10'd4) begin
			wyear = year_s10 - 14'd1;
			tm1   = 9'(u + 10'd361 + 10'(leap_prev_s10));
		end else if (u > diy + 10'd3) begin
			wyear = year_s10 + 14'd1;
			tm1   = 9'(u - 10'd4 - diy);
		end else begin
			wyear = year_s10;
			tm1   = 9'(u - 10'd4);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[10]) begin
			mday_s11    <= mday_s10;
			month_s11   <= month_s10;
			year_s11    <= year_s10;
			ord_s11     <= ord_s10;
			wday_s11    <= wday_s10;
			isowd_s11   <= (wday_s10 == 3'd0) ? 3'd7 : wday_s10;
			quarter_s11 <= quarter;
			doq_s11     <= 7'(ord_s10 - qoff);
			wyear_s11   <= wyear;
			tm1_s11     <= tm1;
			cmd_s11     <= cmd_s10;
		end
	end

	// ---------------- stage 12: week number, select, output word ----------
	logic [18:0] p7;
	logic [5:0]  week;
	logic [13:0] value;
	logic        known;
	logic [13:0] value_s12;
	logic        known_s12;

	assign p7   = tm1_s11 * M_7;
	assign week = p7[17:12] + 6'd1;

	always_comb begin
		known = 1'b1;
		unique case (cmd_s11)
			dce_pkg::CMD_DAY:      value = 14'(mday_s11);
			dce_pkg::CMD_MONTH:    value = 14'(month_s11);
			dce_pkg::CMD_YEAR:     value = year_s11;
			dce_pkg::CMD_WEEKDAY:  value = 14'(wday_s11);
			dce_pkg::CMD_ORDINAL:  value = 14'(ord_s11);
			dce_pkg::CMD_ISOWDAY:  value = 14'(isowd_s11);
			dce_pkg::CMD_WEEK:     value = 14'(week);
			dce_pkg::CMD_WEEKYEAR: value = wyear_s11;
			dce_pkg::CMD_QUARTER:  value = 14'(quarter_s11);
			dce_pkg::CMD_DOQ:      value = 14'(doq_s11);
			default: begin
				value = '0;
				known = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load[11]) begin
			value_s12 <= value;
			known_s12 <= known;
		end
	end

	assign component_value = value_s12;
	assign valid_res       = known_s12;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Randomized check of date_component_extract_core against a calendar predictor.
// A queue of timestamp queries feeds a falling-edge driver on the request side.
// A rising-edge monitor predicts each accepted word's component and compares
// every response with the oldest prediction. Both sides idle in random bursts.
// ----------------------------------------------------------------------------

module tb;

	localparam logic [3:0] CMD_BAD_LO  = 4'd10;
	localparam logic [3:0] CMD_BAD_MID = 4'd12;
	localparam logic [3:0] CMD_BAD_HI  = 4'd15;

	localparam longint FIRST_SECOND = -64'sd62135596800;
	localparam longint LAST_SECOND  = 64'sd253402300799;
	localparam longint unsigned SECOND_SPAN = 64'd315537897600;
	localparam longint SECS_PER_DAY = 86400;
	localparam longint RAW_MIN = -(64'sd1 <<< 38);
	localparam longint RAW_MAX = (64'sd1 <<< 38) - 1;

	localparam int unsigned RANDOM_QUERIES = 2000;
	localparam int unsigned CALM_TAIL      = 250;

	typedef struct {
		logic [3:0]         cmd;
		logic signed [38:0] secs;
		bit                 drain;
	} date_query_t;

	typedef struct {
		logic [13:0] value;
		logic        known;
	} component_t;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	logic [3:0]         command;
	logic signed [38:0] epoch_seconds;
	logic               rsp_valid;
	logic               rsp_ready;
	logic [13:0]        component_value;
	logic               valid_res;

	date_query_t date_queries[$];
	component_t  component_expect_q[$];

	date_query_t next_q;
	component_t  want;
	component_t  got_front;
	longint      stamp_seen;

	bit          req_fire;
	bit          tail_calm;
	int unsigned send_gap;
	int unsigned recv_gap;
	int unsigned send_pct;
	int unsigned recv_pct;
	int unsigned phase_cnt;

	int unsigned mismatches;
	int unsigned words_sent;
	int unsigned words_checked;
	int unsigned clamped_seen;
	int unsigned unknown_seen;

	date_component_extract_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.command         (command),
		.epoch_seconds   (epoch_seconds),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.component_value (component_value),
		.valid_res       (valid_res)
	);

	// ------------------------------------------------------------------
	// calendar arithmetic
	// ------------------------------------------------------------------
	function automatic longint floor_quot(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	function automatic longint days_of_date(input longint y, input longint m,
			input longint d);
		longint yy, era, yoe, mm, doy, doe;
		yy = (m <= 2) ? y - 1 : y;
		era = floor_quot(yy, 400);
		yoe = yy - era * 400;
		mm = (m > 2) ? m - 3 : m + 9;
		doy = (153 * mm + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	function automatic void split_days(input longint z, output longint y,
			output longint m, output longint d);
		longint zz, era, doe, yoe, doy, mp;
		zz = z + 719468;
		era = floor_quot(zz, 146097);
		doe = zz - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		d = doy - (153 * mp + 2) / 5 + 1;
		m = (mp < 10) ? mp + 3 : mp - 9;
		y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
	endfunction

	function automatic component_t calendar_component(input logic [3:0] sel,
			input logic signed [38:0] stamp);
		component_t r;
		longint s, day_no, wd, yr, mo, md, thu, ty, tm, td, v;
		s = stamp;
		if (s < FIRST_SECOND) begin
			s = FIRST_SECOND;
		end
		if (s > LAST_SECOND) begin
			s = LAST_SECOND;
		end
		day_no = floor_quot(s, SECS_PER_DAY);
		split_days(day_no, yr, mo, md);
		wd = ((day_no % 7) + 11) % 7;
		r.known = 1'b1;
		v = 0;
		case (sel)
			dce_pkg::CMD_DAY:      v = md;
			dce_pkg::CMD_MONTH:    v = mo;
			dce_pkg::CMD_YEAR:     v = yr;
			dce_pkg::CMD_WEEKDAY:  v = wd;
			dce_pkg::CMD_ORDINAL:  v = day_no - days_of_date(yr, 1, 1) + 1;
			dce_pkg::CMD_ISOWDAY:  v = (wd == 0) ? 7 : wd;
			dce_pkg::CMD_WEEK, dce_pkg::CMD_WEEKYEAR: begin
				// ISO week belongs to the year of its Thursday
				thu = day_no - ((wd + 6) % 7) + 3;
				split_days(thu, ty, tm, td);
				if (sel == dce_pkg::CMD_WEEK) begin
					v = (thu - days_of_date(ty, 1, 1)) / 7 + 1;
				end else begin
					v = ty;
				end
			end
			dce_pkg::CMD_QUARTER:  v = (mo - 1) / 3 + 1;
			dce_pkg::CMD_DOQ:
				v = day_no - days_of_date(yr, ((mo - 1) / 3) * 3 + 1, 1) + 1;
			default: begin
				r.known = 1'b0;
				v = 0;
			end
		endcase
		if (v < 0) begin
			v = 0;
		end
		r.value = v[13:0];
		return r;
	endfunction

	function automatic void add_query(input logic [3:0] sel, input longint s,
			input bit drn);
		date_query_t q;
		q.cmd = sel;
		q.secs = s[38:0];
		q.drain = drn;
		date_queries.push_back(q);
	endfunction

	function automatic int unsigned pick_pct();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 10;
			2:       return 30;
			default: return 60;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		command = dce_pkg::CMD_DAY;
		epoch_seconds = '0;
		rsp_ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------
	// request driver and response stall generator
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			phase_cnt++;
			if ((phase_cnt % 300) == 0) begin
				send_pct = pick_pct();
				recv_pct = pick_pct();
			end
			tail_calm = date_queries.size() < CALM_TAIL;

			if (!req_valid || req_fire) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (date_queries.size() == 0 ||
						(date_queries[0].drain && component_expect_q.size() != 0)) begin
					req_valid <= 1'b0;
				end else begin
					next_q = date_queries.pop_front();
					command <= next_q.cmd;
					epoch_seconds <= next_q.secs;
					req_valid <= 1'b1;
					if (!tail_calm && $urandom_range(0, 99) < send_pct) begin
						send_gap = $urandom_range(1, 14);
					end
				end
			end

			if (recv_gap > 0) begin
				recv_gap--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if (!tail_calm && $urandom_range(0, 99) < recv_pct) begin
					recv_gap = $urandom_range(1, 14);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: predict on request, compare on response
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			req_fire = req_valid && req_ready;
			if (req_fire) begin
				want = calendar_component(command, epoch_seconds);
				component_expect_q.push_back(want);
				words_sent++;
				stamp_seen = epoch_seconds;
				if (stamp_seen < FIRST_SECOND || stamp_seen > LAST_SECOND) begin
					clamped_seen++;
				end
				if (!want.known) begin
					unknown_seen++;
				end
			end
			if (rsp_valid && rsp_ready) begin
				if (component_expect_q.size() == 0) begin
					mismatches++;
					$display("%0t: response word with nothing outstanding: value %0d valid_res %0b",
						$time, component_value, valid_res);
				end else begin
					got_front = component_expect_q.pop_front();
					words_checked++;
					if (component_value !== got_front.value) begin
						mismatches++;
						$display("%0t: component_value expected %0d actual %0d",
							$time, got_front.value, component_value);
					end
					if (valid_res !== got_front.known) begin
						mismatches++;
						$display("%0t: valid_res expected %0b actual %0b",
							$time, got_front.known, valid_res);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		longint            s;
		longint            base;
		longint unsigned   rnd;
		int unsigned       k;
		int unsigned       yr;
		int unsigned       mo;
		logic [3:0]        sel;

		send_pct = 20;
		recv_pct = 20;

		// field extremes, every selector, clamping, negative seconds
		add_query(dce_pkg::CMD_DAY,      FIRST_SECOND,      1'b0);
		add_query(dce_pkg::CMD_MONTH,    FIRST_SECOND - 1,  1'b0);
		add_query(dce_pkg::CMD_YEAR,     RAW_MIN,           1'b0);
		add_query(dce_pkg::CMD_WEEKDAY,  RAW_MAX,           1'b0);
		add_query(dce_pkg::CMD_ORDINAL,  LAST_SECOND,       1'b0);
		add_query(dce_pkg::CMD_ISOWDAY,  LAST_SECOND + 1,   1'b0);
		add_query(dce_pkg::CMD_WEEK,     0,                 1'b0);
		add_query(dce_pkg::CMD_WEEKYEAR, -1,                1'b0);
		add_query(dce_pkg::CMD_QUARTER,  -86401,            1'b0);
		add_query(dce_pkg::CMD_DOQ,      86399,             1'b0);
		add_query(CMD_BAD_LO,            LAST_SECOND,       1'b0);
		add_query(CMD_BAD_HI,            RAW_MIN,           1'b0);
		add_query(CMD_BAD_MID,           -86400,            1'b0);
		// ISO week-year differs from calendar year at both ends
		add_query(dce_pkg::CMD_WEEK,     1609459200,        1'b0);
		add_query(dce_pkg::CMD_WEEKYEAR, 1609459200,        1'b0);
		add_query(dce_pkg::CMD_WEEK,     1609372800,        1'b0);
		add_query(dce_pkg::CMD_WEEKYEAR, 1735516800,        1'b0);
		add_query(dce_pkg::CMD_WEEK,     1735516800,        1'b0);
		// leap day and end of a leap year in ordinal and day of quarter
		add_query(dce_pkg::CMD_DOQ,      1709164800,        1'b0);
		add_query(dce_pkg::CMD_ORDINAL,  1735603200,        1'b0);
		add_query(dce_pkg::CMD_DOQ,      1735603200,        1'b0);
		add_query(dce_pkg::CMD_WEEK,     LAST_SECOND,       1'b0);
		add_query(dce_pkg::CMD_WEEKYEAR, FIRST_SECOND,      1'b0);
		add_query(dce_pkg::CMD_DAY,      RAW_MAX,           1'b0);

		for (k = 0; k < RANDOM_QUERIES; k++) begin
			if ($urandom_range(0, 99) < 85) begin
				sel = 4'($urandom_range(dce_pkg::CMD_DAY, dce_pkg::CMD_DOQ));
			end else begin
				sel = 4'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					rnd = {$urandom, $urandom};
					s = FIRST_SECOND + longint'(rnd % SECOND_SPAN);
				end
				5, 6: begin
					// around month starts, often the new year
					yr = $urandom_range(1, 9999);
					mo = $urandom_range(0, 1) ? 1 : $urandom_range(1, 12);
					base = days_of_date(longint'(yr), longint'(mo), 1)
						+ longint'($urandom_range(0, 20)) - 10;
					s = base * SECS_PER_DAY + longint'($urandom_range(0, 86399));
				end
				7: begin
					base = $urandom_range(0, 1) ? FIRST_SECOND : LAST_SECOND;
					s = base + longint'($urandom_range(0, 400000)) - 200000;
				end
				default: begin
					s = longint'({$urandom, $urandom});
				end
			endcase
			add_query(sel, s, (k % 500) == 0);
		end

		while (date_queries.size() != 0 || req_valid) begin
			@(posedge clk);
		end
		while (component_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (dce_pkg::STAGES + 20) @(posedge clk);

		$display("Sent %0d request words, checked %0d responses.", words_sent, words_checked);
		$display("Out-of-range timestamps: %0d, unknown selectors: %0d.",
			clamped_seen, unknown_seen);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule
